[rtl/bit_field_pack_unpack_engine_macros.svh]
// Assertion macros for the bit field pack/unpack engine
`ifndef BIT_FIELD_PACK_UNPACK_ENGINE_MACROS_SVH
`define BIT_FIELD_PACK_UNPACK_ENGINE_MACROS_SVH

// same-cycle implication
`define BFPE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfpe check failed: same-cycle rule");

// next-cycle implication
`define BFPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfpe check failed: next-cycle rule");

`endif

[rtl/bfpe_pkg.sv]
`timescale 1ns / 1ps

package bfpe_pkg;

    localparam int RD_W  = 32;
    localparam int ACC_W = RD_W + 8;

    localparam logic [1:0] OP_GET      = 2'd0;
    localparam logic [1:0] OP_SET      = 2'd1;
    localparam logic [1:0] OP_APPEND   = 2'd2;
    localparam logic [1:0] OP_RESETPOS = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [14:0] bit_offset;
        logic [5:0]  bit_count;
        logic [31:0] write_value;
    } in_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [15:0] append_position;
    } out_t;

    typedef struct packed {
        logic [12:0] first_byte;
        logic [13:0] last_byte;
        logic [3:0]  nbytes;
        logic [2:0]  trail;
        logic [1:0]  status;
        logic        go;
    } dec_t;

endpackage

[rtl/bfpe_store.sv]
`timescale 1ns / 1ps

module bfpe_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/bfpe_decode.sv]
`timescale 1ns / 1ps

module bfpe_decode #(
    parameter int STORE_BYTES = 4096,
    parameter int FIELD_BITS  = 32
) (
    input  bfpe_pkg::in_t  item,
    input  logic [15:0]    cursor,
    output bfpe_pkg::dec_t dec
);

    localparam int unsigned STORE_BITS = STORE_BYTES * 8;

    logic [15:0] start;
    logic [16:0] end_bit;
    logic [16:0] last_bit;
    logic        is_pos;
    logic        zero_cnt;

    always_comb
    begin
        is_pos   = (item.opcode == bfpe_pkg::OP_RESETPOS);
        zero_cnt = (item.bit_count == 6'd0);
        start    = (item.opcode == bfpe_pkg::OP_APPEND) ? cursor : {1'b0, item.bit_offset};
        end_bit  = {1'b0, start} + 17'(item.bit_count);
        last_bit = end_bit - 17'd1;

        if (is_pos || zero_cnt)
        begin
            dec.status = bfpe_pkg::ST_OK;
        end
        else if ({26'b0, item.bit_count} > 32'(FIELD_BITS))
        begin
            dec.status = bfpe_pkg::ST_COUNT;
        end
        else if ({15'b0, end_bit} > 32'(STORE_BITS))
        begin
            dec.status = bfpe_pkg::ST_RANGE;
        end
        else
        begin
            dec.status = bfpe_pkg::ST_OK;
        end

        dec.go         = !is_pos && !zero_cnt && (dec.status == bfpe_pkg::ST_OK);
        dec.first_byte = start[15:3];
        dec.last_byte  = last_bit[16:3];
        dec.trail      = ~last_bit[2:0];
        dec.nbytes     = 4'(last_bit[16:3] - {1'b0, start[15:3]} + 14'd1);
    end

endmodule

[rtl/bit_field_pack_unpack_engine.sv]
`timescale 1ns / 1ps
// Bit field pack/unpack engine.
// Input channel in_valid/in_ready carries one operation beat (get, set, append,
// reset position); output channel out_valid/out_ready returns one result beat
// per operation with the field read, a status and the append position.
// The byte store is a single-port-read, single-port-write byte memory with a
// registered read. A field touching n bytes (1 to 5 for 32-bit fields) is
// streamed through it: one byte read per cycle, each byte written back in the
// cycle after its read for set and append.
// A memory operation runs its reads in the run state, then the done state loads
// the result into the output register; reset position, zero count and flagged
// items go straight to the done state without touching the store.
// in_ready is high only while no operation is in progress.
// Reset clears the append position and all control state; store contents are
// undefined until written, and no clearing pass runs.
// When the receiver stalls, the finished result holds in the output register
// and the next result waits in the engine until that register frees up.

`include "bit_field_pack_unpack_engine_macros.svh"

module bit_field_pack_unpack_engine #(
    parameter int STORE_BYTES = 4096,
    parameter int FIELD_BITS  = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bfpe_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output bfpe_pkg::out_t out_data
);

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int W      = FIELD_BITS + 8;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    bfpe_pkg::dec_t dec;

    logic [1:0]                 state_reg;
    logic [15:0]                cursor_reg;
    logic [1:0]                 op_reg;
    logic [5:0]                 cnt_reg;
    logic [1:0]                 status_reg;
    logic [2:0]                 trail_reg;
    logic                       go_reg;
    logic [3:0]                 rd_left_reg;
    logic                       rd_pend_reg;
    logic [ADDR_W-1:0]          rd_addr_reg;
    logic [ADDR_W-1:0]          wr_addr_reg;
    logic [bfpe_pkg::ACC_W-1:0] acc_reg;
    logic [W-1:0]               val_reg;
    logic [W-1:0]               msk_reg;
    logic                       out_valid_reg;
    bfpe_pkg::out_t             out_data_reg;

    logic                       accept;
    logic                       rd_en;
    logic                       wr_en;
    logic [7:0]                 rd_data;
    logic [7:0]                 wr_data;
    logic                       load_out;
    logic [bfpe_pkg::ACC_W-1:0] acc_sh;
    logic [bfpe_pkg::RD_W-1:0]  rmask;
    logic [bfpe_pkg::RD_W-1:0]  rv;

    bfpe_decode #(
        .STORE_BYTES (STORE_BYTES),
        .FIELD_BITS  (FIELD_BITS)
    ) u_decode (
        .item   (in_data),
        .cursor (cursor_reg),
        .dec    (dec)
    );

    bfpe_store #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        accept   = in_valid && in_ready;
        rd_en    = (state_reg == S_RUN) && (rd_left_reg != 4'd0);
        wr_en    = (state_reg == S_RUN) && rd_pend_reg && (op_reg != bfpe_pkg::OP_GET);
        wr_data  = (rd_data & ~msk_reg[7:0]) | (val_reg[7:0] & msk_reg[7:0]);
        load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

        acc_sh = acc_reg >> trail_reg;
        if (cnt_reg >= 6'(bfpe_pkg::RD_W))
        begin
            rmask = '1;
        end
        else
        begin
            rmask = (bfpe_pkg::RD_W'(1) << cnt_reg) - bfpe_pkg::RD_W'(1);
        end
        rv = acc_sh[bfpe_pkg::RD_W-1:0] & rmask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= 16'd0;
            rd_left_reg   <= 4'd0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rd_left_reg <= dec.go ? dec.nbytes : 4'd0;
                        state_reg   <= dec.go ? S_RUN : S_DONE;
                        if (in_data.opcode == bfpe_pkg::OP_RESETPOS)
                        begin
                            cursor_reg <= 16'd0;
                        end
                        else if (dec.go && (in_data.opcode == bfpe_pkg::OP_APPEND))
                        begin
                            cursor_reg <= cursor_reg + 16'(in_data.bit_count);
                        end
                    end
                end
                S_RUN:
                begin
                    if (rd_en)
                    begin
                        rd_left_reg <= rd_left_reg - 4'd1;
                    end
                    else if (rd_pend_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= in_data.opcode;
            cnt_reg     <= in_data.bit_count;
            status_reg  <= dec.status;
            trail_reg   <= dec.trail;
            go_reg      <= dec.go;
            acc_reg     <= '0;
            wr_addr_reg <= ADDR_W'(dec.last_byte);
            val_reg     <= W'(in_data.write_value) << dec.trail;
            msk_reg     <= ((W'(1) << in_data.bit_count) - W'(1)) << dec.trail;
            if (in_data.opcode == bfpe_pkg::OP_GET)
            begin
                rd_addr_reg <= ADDR_W'(dec.first_byte);
            end
            else
            begin
                rd_addr_reg <= ADDR_W'(dec.last_byte);
            end
        end
        else
        begin
            if (rd_en)
            begin
                if (op_reg == bfpe_pkg::OP_GET)
                begin
                    rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                end
                else
                begin
                    rd_addr_reg <= rd_addr_reg - ADDR_W'(1);
                end
            end
            if ((state_reg == S_RUN) && rd_pend_reg)
            begin
                if (op_reg == bfpe_pkg::OP_GET)
                begin
                    acc_reg <= {acc_reg[bfpe_pkg::ACC_W-9:0], rd_data};
                end
                else
                begin
                    val_reg     <= val_reg >> 8;
                    msk_reg     <= msk_reg >> 8;
                    wr_addr_reg <= wr_addr_reg - ADDR_W'(1);
                end
            end
        end

        if (load_out)
        begin
            out_data_reg.read_value      <= (go_reg && (op_reg == bfpe_pkg::OP_GET)) ? rv : '0;
            out_data_reg.status          <= status_reg;
            out_data_reg.append_position <= cursor_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BFPE_ASSERT_NOW(a_wr_only_set, wr_en, (op_reg == bfpe_pkg::OP_SET) || (op_reg == bfpe_pkg::OP_APPEND))
    `BFPE_ASSERT_NOW(a_no_rw_clash, rd_en && wr_en, rd_addr_reg != wr_addr_reg)
    `BFPE_ASSERT_NOW(a_tail_pending, (state_reg == S_RUN) && (rd_left_reg == 4'd0), rd_pend_reg)
    `BFPE_ASSERT_NEXT(a_cursor_hold, !accept, $stable(cursor_reg))

endmodule
